>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers for the equaliser RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication held at the same edge, masked while in reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent at one edge, consequent at the next edge, masked while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/eqb_pkg.sv
// ---------------------------------------------------------------------------
// eqb_pkg
// Shared widths, types, register map and saturation helpers of the equaliser.
// ---------------------------------------------------------------------------
package eqb_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DELAY_W    = 48;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 19;
  localparam int Y_W        = DELAY_W + 1 - FRAC_BITS;
  localparam int ACC_W      = COEF_W + Y_W + 1;
  localparam int SUM_W      = SAMPLE_W + 2;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [Y_W-1:0]      opb_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [DELAY_W-1:0]  delay_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = -16'sh8000;
  localparam delay_t  DELAY_MAX  = {1'b0, {(DELAY_W-1){1'b1}}};
  localparam delay_t  DELAY_MIN  = {1'b1, {(DELAY_W-1){1'b0}}};

  // register map, word index = paddr[4:2]
  localparam logic [2:0] REG_LOW_GAIN  = 3'd0;
  localparam logic [2:0] REG_MID_GAIN  = 3'd1;
  localparam logic [2:0] REG_HIGH_GAIN = 3'd2;
  localparam logic [2:0] REG_FB_A1     = 3'd3;
  localparam logic [2:0] REG_FB_A2     = 3'd4;
  localparam logic [2:0] REG_FEED_K    = 3'd5;

  localparam logic [16:0]        LOW_GAIN_RST  = 17'd45875;
  localparam logic [16:0]        MID_GAIN_RST  = 17'd82207;
  localparam logic [16:0]        HIGH_GAIN_RST = 17'd58254;
  localparam logic signed [17:0] FB_A1_RST     = -18'sd62019;
  localparam logic signed [17:0] FB_A2_RST     = 18'sd20225;
  localparam logic signed [16:0] FEED_K_RST    = 17'sd16384;

  typedef struct packed {
    logic [16:0]        low_gain;
    logic [16:0]        mid_gain;
    logic [16:0]        high_gain;
    logic signed [17:0] feedback_a1;
    logic signed [17:0] feedback_a2;
    logic signed [16:0] feed_k;
  } cfg_t;

  typedef enum logic [1:0] {
    BAND_LOW  = 2'd0,
    BAND_MID  = 2'd1,
    BAND_HIGH = 2'd2
  } band_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B0,
    ST_B1,
    ST_A1,
    ST_B2,
    ST_A2,
    ST_GAIN,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    COEF_K,
    COEF_B1,
    COEF_B2,
    COEF_NA1,
    COEF_NA2,
    COEF_GAIN
  } coef_sel_t;

  typedef enum logic [1:0] {
    OPB_X,
    OPB_Y,
    OPB_YC
  } opb_sel_t;

  typedef enum logic [1:0] {
    ADD_ZERO,
    ADD_ACC,
    ADD_D1,
    ADD_D2
  } add_sel_t;

  typedef struct packed {
    logic      in_ready;
    logic      load_x;
    logic      load_y;
    logic      wr_d1;
    logic      wr_d2;
    logic      accum_band;
    logic      load_out;
    band_t     band;
    coef_sel_t coef_sel;
    opb_sel_t  opb_sel;
    add_sel_t  add_sel;
  } ctl_t;

  function automatic sample_t clamp_sample(input acc_t v);
    acc_t hi_lim;
    acc_t lo_lim;
    sample_t res;
    hi_lim = acc_t'(SAMPLE_MAX);
    lo_lim = acc_t'(SAMPLE_MIN);
    if (v > hi_lim) begin
      res = SAMPLE_MAX;
    end else if (v < lo_lim) begin
      res = SAMPLE_MIN;
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  function automatic delay_t sat_delay(input acc_t v);
    acc_t hi_lim;
    acc_t lo_lim;
    delay_t res;
    hi_lim = acc_t'(DELAY_MAX);
    lo_lim = acc_t'(DELAY_MIN);
    if (v > hi_lim) begin
      res = DELAY_MAX;
    end else if (v < lo_lim) begin
      res = DELAY_MIN;
    end else begin
      res = v[DELAY_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/three_band_biquad_equalizer.sv
// ---------------------------------------------------------------------------
// three_band_biquad_equalizer
// Three transposed direct-form-II biquads (low, mid, high) with shared
// feedback, per-band gain and a saturating sum, on one shared MAC.
// ---------------------------------------------------------------------------
//
//   channel   handshake              word
//   --------  ---------------------  ------------------------------------
//   in        in_valid / in_ready    in_audio_in   signed 16-bit sample
//   out       out_valid / out_ready  out_audio_out signed 16-bit sample
//   cfg       psel/penable/pwrite    paddr, pwdata, prdata (32-bit APB)
//
// Each accepted word runs seven sequencer steps per band over three bands,
// then the output register is loaded. The sequencer then returns to idle
// to take the next word, so a new word is not accepted before the last one
// has been loaded into the output register. The single multiply-accumulate
// unit is the reason for this serial schedule.
// in_ready is high only while the sequencer idles; a result left untaken
// holds the sequencer in its output step until out_ready frees the register.
// Synchronous reset restores the register defaults and clears all six delay
// terms at once.
// ---------------------------------------------------------------------------
module three_band_biquad_equalizer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               in_audio_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [15:0]               out_audio_out,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [eqb_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [eqb_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [eqb_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  eqb_pkg::cfg_t    cfg;
  eqb_pkg::ctl_t    ctl;
  eqb_pkg::acc_t    acc;
  eqb_pkg::coef_t   coef;
  eqb_pkg::opb_t    opb;
  eqb_pkg::acc_t    addend;

  eqb_pkg::sample_t x_r;
  eqb_pkg::opb_t    y_r;
  eqb_pkg::sum_t    sum_r;
  eqb_pkg::delay_t  d1_r [3];
  eqb_pkg::delay_t  d2_r [3];
  eqb_pkg::delay_t  d1_sel;
  eqb_pkg::delay_t  d2_sel;
  logic             out_valid_r;
  eqb_pkg::sample_t out_audio_r;

  eqb_pkg::coef_t   k_c;
  eqb_pkg::coef_t   k2_c;
  eqb_pkg::coef_t   gain_c;
  eqb_pkg::sample_t band_v;
  logic             out_free;

  eqb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;

  eqb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctl      (ctl)
  );

  eqb_mac u_mac (
    .clk    (clk),
    .coef   (coef),
    .opb    (opb),
    .addend (addend),
    .acc    (acc)
  );

  // base coefficient and its double, sign-extended to the MAC width
  assign k_c  = eqb_pkg::coef_t'($signed(cfg.feed_k));
  assign k2_c = k_c <<< 1;

  // pick the delay terms and gain of the band in flight
  always_comb begin
    unique case (ctl.band)
      eqb_pkg::BAND_LOW: begin
        d1_sel = d1_r[0];
        d2_sel = d2_r[0];
        gain_c = eqb_pkg::coef_t'({2'b00, cfg.low_gain});
      end
      eqb_pkg::BAND_MID: begin
        d1_sel = d1_r[1];
        d2_sel = d2_r[1];
        gain_c = eqb_pkg::coef_t'({2'b00, cfg.mid_gain});
      end
      eqb_pkg::BAND_HIGH: begin
        d1_sel = d1_r[2];
        d2_sel = d2_r[2];
        gain_c = eqb_pkg::coef_t'({2'b00, cfg.high_gain});
      end
      default: begin
        d1_sel = d1_r[0];
        d2_sel = d2_r[0];
        gain_c = eqb_pkg::coef_t'({2'b00, cfg.low_gain});
      end
    endcase
  end

  // coefficient operand: numerator patterns are k,2k,k / k,0,-k / k,-2k,k;
  // feedback enters negated so the MAC only ever adds
  always_comb begin
    case (ctl.coef_sel)
      eqb_pkg::COEF_K: coef = k_c;
      eqb_pkg::COEF_B1: begin
        unique case (ctl.band)
          eqb_pkg::BAND_LOW:  coef = k2_c;
          eqb_pkg::BAND_HIGH: coef = -k2_c;
          default:            coef = '0;
        endcase
      end
      eqb_pkg::COEF_B2: begin
        unique case (ctl.band)
          eqb_pkg::BAND_MID: coef = -k_c;
          default:           coef = k_c;
        endcase
      end
      eqb_pkg::COEF_NA1:  coef = -eqb_pkg::coef_t'($signed(cfg.feedback_a1));
      eqb_pkg::COEF_NA2:  coef = -eqb_pkg::coef_t'($signed(cfg.feedback_a2));
      eqb_pkg::COEF_GAIN: coef = gain_c;
      default:            coef = '0;
    endcase
  end

  // data operand: input sample, raw filter output, or clamped filter output
  always_comb begin
    case (ctl.opb_sel)
      eqb_pkg::OPB_X:  opb = eqb_pkg::opb_t'(x_r);
      eqb_pkg::OPB_Y:  opb = y_r;
      eqb_pkg::OPB_YC: opb = eqb_pkg::opb_t'(eqb_pkg::clamp_sample(eqb_pkg::acc_t'(y_r)));
      default:         opb = '0;
    endcase
  end

  always_comb begin
    case (ctl.add_sel)
      eqb_pkg::ADD_ACC: addend = acc;
      eqb_pkg::ADD_D1:  addend = eqb_pkg::acc_t'(d1_sel);
      eqb_pkg::ADD_D2:  addend = eqb_pkg::acc_t'(d2_sel);
      default:          addend = '0;
    endcase
  end

  // gained band: drop the fraction bits, then saturate to a sample
  assign band_v = eqb_pkg::clamp_sample(
                    eqb_pkg::acc_t'($signed(acc[eqb_pkg::ACC_W-1:eqb_pkg::FRAC_BITS])));

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load_x) begin
      x_r   <= in_audio_in;
      sum_r <= '0;
    end else if (ctl.accum_band) begin
      sum_r <= sum_r + eqb_pkg::sum_t'(band_v);
    end
    // filter output: floor shift of b0*x + d1, kept unclamped for feedback
    if (ctl.load_y) begin
      y_r <= $signed(acc[eqb_pkg::FRAC_BITS+eqb_pkg::Y_W-1:eqb_pkg::FRAC_BITS]);
    end
    if (ctl.load_out) begin
      out_audio_r <= eqb_pkg::clamp_sample(eqb_pkg::acc_t'(sum_r));
    end
  end

  // delay terms: saturate on write back, clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= '0;
        d2_r[i] <= '0;
      end
    end else begin
      if (ctl.wr_d1) begin
        unique case (ctl.band)
          eqb_pkg::BAND_LOW:  d1_r[0] <= eqb_pkg::sat_delay(acc);
          eqb_pkg::BAND_MID:  d1_r[1] <= eqb_pkg::sat_delay(acc);
          eqb_pkg::BAND_HIGH: d1_r[2] <= eqb_pkg::sat_delay(acc);
          default: ;
        endcase
      end
      if (ctl.wr_d2) begin
        unique case (ctl.band)
          eqb_pkg::BAND_LOW:  d2_r[0] <= eqb_pkg::sat_delay(acc);
          eqb_pkg::BAND_MID:  d2_r[1] <= eqb_pkg::sat_delay(acc);
          eqb_pkg::BAND_HIGH: d2_r[2] <= eqb_pkg::sat_delay(acc);
          default: ;
        endcase
      end
    end
  end

  // output valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_ready      = ctl.in_ready;
  assign out_valid     = out_valid_r;
  assign out_audio_out = out_audio_r;

endmodule

>>> rtl/eqb_regs.sv
// ---------------------------------------------------------------------------
// eqb_regs
// APB-style register bank holding the gains and shared filter coefficients.
// ---------------------------------------------------------------------------
module eqb_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [eqb_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [eqb_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [eqb_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output eqb_pkg::cfg_t                    cfg
);

  eqb_pkg::cfg_t cfg_r;
  eqb_pkg::cfg_t cfg_nxt;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        eqb_pkg::REG_LOW_GAIN:  cfg_nxt.low_gain    = pwdata[16:0];
        eqb_pkg::REG_MID_GAIN:  cfg_nxt.mid_gain    = pwdata[16:0];
        eqb_pkg::REG_HIGH_GAIN: cfg_nxt.high_gain   = pwdata[16:0];
        eqb_pkg::REG_FB_A1:     cfg_nxt.feedback_a1 = pwdata[17:0];
        eqb_pkg::REG_FB_A2:     cfg_nxt.feedback_a2 = pwdata[17:0];
        eqb_pkg::REG_FEED_K:    cfg_nxt.feed_k      = pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      eqb_pkg::REG_LOW_GAIN:  prdata = {15'd0, cfg_r.low_gain};
      eqb_pkg::REG_MID_GAIN:  prdata = {15'd0, cfg_r.mid_gain};
      eqb_pkg::REG_HIGH_GAIN: prdata = {15'd0, cfg_r.high_gain};
      eqb_pkg::REG_FB_A1:     prdata = {14'd0, cfg_r.feedback_a1};
      eqb_pkg::REG_FB_A2:     prdata = {14'd0, cfg_r.feedback_a2};
      eqb_pkg::REG_FEED_K:    prdata = {15'd0, cfg_r.feed_k};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_gain    <= eqb_pkg::LOW_GAIN_RST;
      cfg_r.mid_gain    <= eqb_pkg::MID_GAIN_RST;
      cfg_r.high_gain   <= eqb_pkg::HIGH_GAIN_RST;
      cfg_r.feedback_a1 <= eqb_pkg::FB_A1_RST;
      cfg_r.feedback_a2 <= eqb_pkg::FB_A2_RST;
      cfg_r.feed_k      <= eqb_pkg::FEED_K_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/eqb_mac.sv
// ---------------------------------------------------------------------------
// eqb_mac
// Shared multiply-accumulate unit: acc <= addend + coef * operand.
// ---------------------------------------------------------------------------
module eqb_mac (
  input  logic                 clk,
  input  eqb_pkg::coef_t       coef,
  input  eqb_pkg::opb_t        opb,
  input  eqb_pkg::acc_t        addend,
  output eqb_pkg::acc_t        acc
);

  logic signed [eqb_pkg::COEF_W+eqb_pkg::Y_W-1:0] prod;
  eqb_pkg::acc_t acc_r;
  eqb_pkg::acc_t acc_nxt;

  assign prod    = coef * opb;
  assign acc_nxt = addend + eqb_pkg::acc_t'(prod);
  assign acc     = acc_r;

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

>>> rtl/eqb_ctrl.sv
// ---------------------------------------------------------------------------
// eqb_ctrl
// Sequencer stepping the shared MAC through three bands of seven steps each.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module eqb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_free,
  output eqb_pkg::ctl_t  ctl
);

  eqb_pkg::state_t state_r;
  eqb_pkg::state_t state_nxt;
  eqb_pkg::band_t  band_r;
  eqb_pkg::band_t  band_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    band_nxt  = band_r;
    unique case (state_r)
      eqb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = eqb_pkg::ST_B0;
          band_nxt  = eqb_pkg::BAND_LOW;
        end
      end
      eqb_pkg::ST_B0:   state_nxt = eqb_pkg::ST_B1;
      eqb_pkg::ST_B1:   state_nxt = eqb_pkg::ST_A1;
      eqb_pkg::ST_A1:   state_nxt = eqb_pkg::ST_B2;
      eqb_pkg::ST_B2:   state_nxt = eqb_pkg::ST_A2;
      eqb_pkg::ST_A2:   state_nxt = eqb_pkg::ST_GAIN;
      eqb_pkg::ST_GAIN: state_nxt = eqb_pkg::ST_ACC;
      eqb_pkg::ST_ACC: begin
        unique case (band_r)
          eqb_pkg::BAND_LOW: begin
            band_nxt  = eqb_pkg::BAND_MID;
            state_nxt = eqb_pkg::ST_B0;
          end
          eqb_pkg::BAND_MID: begin
            band_nxt  = eqb_pkg::BAND_HIGH;
            state_nxt = eqb_pkg::ST_B0;
          end
          default: state_nxt = eqb_pkg::ST_OUT;
        endcase
      end
      eqb_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = eqb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = eqb_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl          = '0;
    ctl.band     = band_r;
    ctl.coef_sel = eqb_pkg::COEF_K;
    ctl.opb_sel  = eqb_pkg::OPB_X;
    ctl.add_sel  = eqb_pkg::ADD_ZERO;
    unique case (state_r)
      eqb_pkg::ST_IDLE: begin
        ctl.in_ready = 1'b1;
        ctl.load_x   = in_valid;
      end
      eqb_pkg::ST_B0: begin
        ctl.coef_sel = eqb_pkg::COEF_K;
        ctl.opb_sel  = eqb_pkg::OPB_X;
        ctl.add_sel  = eqb_pkg::ADD_D1;
      end
      eqb_pkg::ST_B1: begin
        ctl.load_y   = 1'b1;
        ctl.coef_sel = eqb_pkg::COEF_B1;
        ctl.opb_sel  = eqb_pkg::OPB_X;
        ctl.add_sel  = eqb_pkg::ADD_D2;
      end
      eqb_pkg::ST_A1: begin
        ctl.coef_sel = eqb_pkg::COEF_NA1;
        ctl.opb_sel  = eqb_pkg::OPB_Y;
        ctl.add_sel  = eqb_pkg::ADD_ACC;
      end
      eqb_pkg::ST_B2: begin
        ctl.wr_d1    = 1'b1;
        ctl.coef_sel = eqb_pkg::COEF_B2;
        ctl.opb_sel  = eqb_pkg::OPB_X;
        ctl.add_sel  = eqb_pkg::ADD_ZERO;
      end
      eqb_pkg::ST_A2: begin
        ctl.coef_sel = eqb_pkg::COEF_NA2;
        ctl.opb_sel  = eqb_pkg::OPB_Y;
        ctl.add_sel  = eqb_pkg::ADD_ACC;
      end
      eqb_pkg::ST_GAIN: begin
        ctl.wr_d2    = 1'b1;
        ctl.coef_sel = eqb_pkg::COEF_GAIN;
        ctl.opb_sel  = eqb_pkg::OPB_YC;
        ctl.add_sel  = eqb_pkg::ADD_ZERO;
      end
      eqb_pkg::ST_ACC: begin
        ctl.accum_band = 1'b1;
      end
      eqb_pkg::ST_OUT: begin
        ctl.load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eqb_pkg::ST_IDLE;
      band_r  <= eqb_pkg::BAND_LOW;
    end else begin
      state_r <= state_nxt;
      band_r  <= band_nxt;
    end
  end

  `ASSERT_NEXT(a_start_low, clk, rst_n, ctl.load_x,
    state_r == eqb_pkg::ST_B0 && band_r == eqb_pkg::BAND_LOW,
    "sample start did not enter the low band")
  `ASSERT_NEXT(a_last_band, clk, rst_n,
    state_r == eqb_pkg::ST_ACC && band_r == eqb_pkg::BAND_HIGH,
    state_r == eqb_pkg::ST_OUT, "high band did not hand over to output")
  `ASSERT_CLK(a_out_band, clk, rst_n,
    state_r == eqb_pkg::ST_OUT |-> band_r == eqb_pkg::BAND_HIGH,
    "output reached before all bands ran")

endmodule
